// ----- hw/rtl/ile_pkg.sv -----
// ----------------------------------------------------------------------------
// ile_pkg
// Shared types and constants for the indexed list engine.
// ----------------------------------------------------------------------------
package ile_pkg;

  localparam int unsigned Capacity  = 64;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned IdxW      = $clog2(Capacity);
  localparam int unsigned CntW      = $clog2(Capacity + 1);

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_REAR  = 3'd1,
    OP_INS_IDX   = 3'd2,
    OP_REM_FRONT = 3'd3,
    OP_REM_REAR  = 3'd4,
    OP_REM_IDX   = 3'd5,
    OP_READ_IDX  = 3'd6,
    OP_NOP       = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_READ   = 2'd3
  } act_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [5:0]  position;
    logic [31:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  entry_count;
    logic [31:0] data_out;
  } out_item_t;

  // Classified command passed from front end to back end.
  typedef struct packed {
    act_e                 act;
    logic [6:0]           pos;
    logic [DataWidth-1:0] word;
  } cmd_t;

endpackage

// ----- hw/rtl/indexed_list_engine.sv -----
// ----------------------------------------------------------------------------
// indexed_list_engine
// Ordered list of words with indexed insert, remove and read.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid_i / in_ready_o carry in_item_i (operation,
//                 position, data_in). A transfer happens when both are high.
//   out channel : out_valid_o / out_ready_i carry out_item_o (status,
//                 entry_count, data_out); exactly one result per input.
//   Path: an item waits in the front command queue, then its result in
//   the back end's output register.
//   Throughput: one item per cycle while out_ready_i stays high; the back
//   end shifts the entry cell row for each command it takes.
//   Reset: the list is empty; queue and output valid flag are cleared.
//   Stalls: when out_ready_i is low the result holds; the back end stops,
//   the two-entry command queue fills, then in_ready_o drops.
// ----------------------------------------------------------------------------
module indexed_list_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ile_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ile_pkg::out_item_t out_item_o
);
  import ile_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  // Classify and queue.
  ile_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  // Execute on the cell row.
  ile_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .cmd_i(cmd), .out_valid_o, .out_ready_i, .out_item_o
  );

endmodule

// ----- hw/rtl/ile_front.sv -----
// ----------------------------------------------------------------------------
// ile_front
// Accepts input items, classifies them and queues commands for the back end.
// ----------------------------------------------------------------------------
module ile_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ile_pkg::in_item_t in_item_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output ile_pkg::cmd_t     cmd_o
);
  import ile_pkg::*;

  // Two-entry command queue.
  cmd_t       fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  cmd_t       cmd_new;
  logic       push, pop;

  always_comb begin
    cmd_new.word = in_item_i.data_in[DataWidth-1:0];
    cmd_new.pos  = {1'b0, in_item_i.position};
    unique case (in_item_i.operation)
      OP_INS_FRONT: begin cmd_new.act = ACT_INSERT; cmd_new.pos = '0; end
      OP_INS_REAR:  begin cmd_new.act = ACT_INSERT; cmd_new.pos = 7'h7f; end
      OP_INS_IDX:   cmd_new.act = ACT_INSERT;
      OP_REM_FRONT: begin cmd_new.act = ACT_REMOVE; cmd_new.pos = '0; end
      OP_REM_REAR:  begin cmd_new.act = ACT_REMOVE; cmd_new.pos = 7'h7f; end
      OP_REM_IDX:   cmd_new.act = ACT_REMOVE;
      OP_READ_IDX:  cmd_new.act = ACT_READ;
      default:      cmd_new.act = ACT_NONE;
    endcase
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= cmd_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count overflow");
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("push lost");
  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> cnt_q == $past(cnt_q) - 2'd1) else $error("pop lost");
`endif
endmodule

// ----- hw/rtl/ile_back.sv -----
// ----------------------------------------------------------------------------
// ile_back
// Shifting row of entry cells; executes one command per cycle into an
// output register, while that register is empty or being read.
// ----------------------------------------------------------------------------
module ile_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  ile_pkg::cmd_t      cmd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ile_pkg::out_item_t out_item_o
);
  import ile_pkg::*;

  logic [DataWidth-1:0] cell_q [Capacity];
  logic [CntW-1:0]      occ_q, occ_d;
  logic                 out_valid_q;
  out_item_t            out_q, out_d;
  logic                 go;
  logic                 full, empty;
  logic [CntW-1:0]      ins_idx, rem_idx;
  logic [DataWidth-1:0] sel_word;
  logic                 do_ins, do_rem;

  assign cmd_ready_o = !out_valid_q || out_ready_i;
  assign go          = cmd_valid_i && cmd_ready_o;
  assign full        = (occ_q == CntW'(Capacity));
  assign empty       = (occ_q == '0);

  always_comb begin
    ins_idx = (CntW'(cmd_i.pos) > occ_q || cmd_i.pos > 7'(Capacity)) ?
              occ_q : CntW'(cmd_i.pos);
    rem_idx = (empty || CntW'(cmd_i.pos) >= occ_q - 1'b1 ||
               cmd_i.pos > 7'(Capacity)) ? occ_q - 1'b1 : CntW'(cmd_i.pos);
    if (cmd_i.act == ACT_READ) sel_word = cell_q[cmd_i.pos[IdxW-1:0]];
    else                       sel_word = cell_q[rem_idx[IdxW-1:0]];
    do_ins = 1'b0;
    do_rem = 1'b0;
    occ_d  = occ_q;
    out_d.status   = ST_DONE;
    out_d.data_out = '0;
    unique case (cmd_i.act)
      ACT_INSERT: begin
        if (full) out_d.status = ST_FULL;
        else begin do_ins = 1'b1; occ_d = occ_q + 1'b1; end
      end
      ACT_REMOVE: begin
        if (empty) out_d.status = ST_EMPTY;
        else begin
          do_rem = 1'b1;
          occ_d  = occ_q - 1'b1;
          out_d.data_out = 32'(sel_word);
        end
      end
      ACT_READ: begin
        if (CntW'(cmd_i.pos) < occ_q && cmd_i.pos < 7'(Capacity))
          out_d.data_out = 32'(sel_word);
        else out_d.status = ST_RANGE;
      end
      default: ;
    endcase
    out_d.entry_count = 7'(occ_d);
  end

  // Each cell shifts, loads the new word, or holds.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Capacity; k++) begin
      if (go && do_ins) begin
        if (CntW'(k) == ins_idx) cell_q[k] <= cmd_i.word;
        else if (CntW'(k) > ins_idx && k > 0) cell_q[k] <= cell_q[(k > 0) ? k-1 : 0];
      end else if (go && do_rem) begin
        if (CntW'(k) >= rem_idx && k < Capacity-1)
          cell_q[k] <= cell_q[(k < Capacity-1) ? k+1 : k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (go) begin
        occ_q       <= occ_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef ASSERT_OFF
  a_occ_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CntW'(Capacity)) else $error("occupancy past capacity");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(out_q)) else $error("result changed");
  a_occ_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !go |=> occ_q == $past(occ_q)) else $error("occupancy moved while idle");
`endif
endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the indexed list engine: directed and random list operations
// with a class-based scoreboard that predicts every result.
// ----------------------------------------------------------------------------
module tb_top;
  import ile_pkg::*;

  // Scoreboard: keeps its own copy of the list and a queue of predicted results.
  class list_scoreboard;
    logic [31:0] words[$];
    out_item_t   pending[$];
    int          errors;
    int          checked;

    function void note_transfer(in_item_t it);
      out_item_t r;
      int unsigned idx;
      r.status   = ST_DONE;
      r.data_out = '0;
      case (op_e'(it.operation))
        OP_INS_FRONT, OP_INS_REAR, OP_INS_IDX: begin
          if (words.size() >= Capacity) begin
            r.status = ST_FULL;
          end else begin
            if (it.operation == OP_INS_FRONT) idx = 0;
            else if (it.operation == OP_INS_REAR) idx = words.size();
            else idx = (it.position > words.size()) ? words.size() : it.position;
            words.insert(idx, it.data_in);
          end
        end
        OP_REM_FRONT, OP_REM_REAR, OP_REM_IDX: begin
          if (words.size() == 0) begin
            r.status = ST_EMPTY;
          end else begin
            if (it.operation == OP_REM_FRONT) idx = 0;
            else if (it.operation == OP_REM_REAR) idx = words.size() - 1;
            else idx = (it.position > words.size() - 1) ? words.size() - 1 : it.position;
            r.data_out = words[idx];
            words.delete(idx);
          end
        end
        OP_READ_IDX: begin
          if (it.position < words.size()) r.data_out = words[it.position];
          else r.status = ST_RANGE;
        end
        default: ;
      endcase
      r.entry_count = 7'(words.size());
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      checked++;
      if (pending.size() == 0) begin
        $error("result with no expectation: %p", got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, got.status);
        errors++;
      end
      if (got.entry_count !== exp.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", exp.entry_count, got.entry_count);
        errors++;
      end
      if (got.data_out !== exp.data_out) begin
        $error("data_out: expected %h, actual %h", exp.data_out, got.data_out);
        errors++;
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  list_scoreboard sb = new();
  int  sent;
  bit  quiet_mode;     // no idling on either side while set
  int  hold_off_at;    // transfer count at which the receiver holds off

  indexed_list_engine dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predict at the transfer edge, then check results on the same edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_transfer(in_item_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_item_o);
  end

  // Drive one item: present it at a falling edge, hold until the transfer.
  // Valid drops only while idling, so back-to-back items keep it high.
  task automatic send_item(op_e op, logic [5:0] pos, logic [31:0] word);
    if (!quiet_mode) begin
      while ($urandom_range(99) < 24) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_item_i  <= '{operation: op, position: pos, data_in: word};
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(3))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Receiver: random stalls, two long hold-offs to fill the command queue.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sent >= hold_off_at && hold_off_at > 0) begin
        hold_off_at = 0;
        out_ready_i <= 1'b0;
        for (n = 0; n < 40; n++) @(negedge clk_i);
      end
      out_ready_i <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 24);
    end
  end

  initial begin
    int k;
    int fill;
    op_e op;
    hold_off_at = 30;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty-list cases first, then fill to full and probe the edges.
    send_item(OP_REM_FRONT, 6'd0, 32'h0);
    send_item(OP_REM_IDX, 6'd63, 32'h0);
    send_item(OP_READ_IDX, 6'd0, 32'h0);
    send_item(OP_NOP, 6'd5, 32'h1234_5678);
    send_item(OP_INS_FRONT, 6'd0, 32'hFFFF_FFFF);
    send_item(OP_INS_REAR, 6'd0, 32'h0000_0001);
    send_item(OP_INS_IDX, 6'd63, 32'hA5A5_A5A5);  // past count: append
    send_item(OP_INS_IDX, 6'd1, 32'h5A5A_5A5A);
    send_item(OP_READ_IDX, 6'd63, 32'h0);         // out of range
    send_item(OP_READ_IDX, 6'd3, 32'h0);
    send_item(OP_REM_IDX, 6'd63, 32'h0);          // past count-1: remove rear
    send_item(OP_REM_IDX, 6'd1, 32'h0);
    send_item(OP_REM_REAR, 6'd0, 32'h0);
    send_item(OP_REM_FRONT, 6'd0, 32'h0);
    for (k = 0; k < 64; k++) send_item(OP_INS_REAR, 6'(k), $urandom());
    send_item(OP_INS_FRONT, 6'd0, 32'hDEAD_BEEF); // full: dropped
    send_item(OP_INS_IDX, 6'd10, 32'hDEAD_BEEF);
    send_item(OP_READ_IDX, 6'd63, 32'h0);
    send_item(OP_REM_IDX, 6'd0, 32'h0);
    hold_off_at = sent + 5;

    // Random: drift between nearly empty and full; a quiet stretch midway.
    fill = 1;
    for (k = 0; k < 570; k++) begin
      quiet_mode = (k >= 300 && k < 400);
      if (k % 120 == 0) fill = !fill;
      case ($urandom_range(9))
        0, 1, 2: op = fill ? OP_INS_REAR : OP_REM_REAR;
        3: op = fill ? OP_INS_IDX : OP_REM_IDX;
        4: op = OP_INS_FRONT;
        5: op = OP_REM_FRONT;
        6: op = OP_INS_IDX;
        7: op = OP_REM_IDX;
        8: op = OP_READ_IDX;
        default: op = op_e'($urandom_range(7));
      endcase
      send_item(op, 6'($urandom_range(63)), rand_word());
    end
    quiet_mode = 1'b0;
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Ran %0d list operations, %0d results checked, list filled and drained.",
             sent, sb.checked);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- indexed_list_engine.f -----
hw/rtl/ile_pkg.sv
hw/rtl/ile_front.sv
hw/rtl/ile_back.sv
hw/rtl/indexed_list_engine.sv
tb/tb_top.sv
